// File: rtl/core/nfci_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the NAND flash command interface: opcodes, window regions,
// error flag positions and register indexes. No dependencies.
package nfci_pkg;

  localparam int unsigned ARRAY_BYTES = 262144;
  localparam int unsigned ARRAY_AW    = 18;
  localparam int unsigned CFG_AW      = 6;
  localparam int unsigned CFG_DW      = 64;

  localparam logic [7:0] OP_READ    = 8'h00;
  localparam logic [7:0] OP_READ_GO = 8'h30;
  localparam logic [7:0] OP_STATUS  = 8'h70;
  localparam logic [7:0] OP_PROG    = 8'h80;
  localparam logic [7:0] OP_PROG_GO = 8'h10;
  localparam logic [7:0] OP_ID      = 8'h90;
  localparam logic [7:0] OP_RESET   = 8'hff;

  localparam logic [19:0] OFF_CMD  = 20'h08000;
  localparam logic [19:0] OFF_ADDR = 20'h10000;
  localparam logic [19:0] OFF_RSVD = 20'hc0000;

  localparam int unsigned FL_MODE  = 0;
  localparam int unsigned FL_RSVD  = 1;
  localparam int unsigned FL_ALIGN = 2;
  localparam int unsigned FL_CMD   = 3;
  localparam int unsigned FL_SEQ   = 4;
  localparam int unsigned FL_BUF   = 5;
  localparam int unsigned FL_ARRAY = 6;

  localparam logic [2:0] REG_PAGE_BYTES  = 3'd0;
  localparam logic [2:0] REG_SPARE_BYTES = 3'd1;
  localparam logic [2:0] REG_WRITE_EN    = 3'd2;
  localparam logic [2:0] REG_DEVICE_ID   = 3'd3;
  localparam logic [2:0] REG_SHARED_OFF  = 3'd4;

  typedef logic [7:0]  byte_t;
  typedef logic [6:0]  flags_t;
  typedef logic [63:0] word_t;

endpackage

// File: rtl/core/nfci_chan_if.sv
`timescale 1ns / 1ps
// Request and response channels of the NAND flash command interface.
// Depends on nfci_pkg.
interface nfci_req_if;
  import nfci_pkg::*;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [25:0] bus_offset;
  logic [3:0]  access_bytes;
  word_t       write_data;
  modport source (output valid, req_type, bus_offset, access_bytes, write_data, input ready);
  modport sink (input valid, req_type, bus_offset, access_bytes, write_data, output ready);
endinterface

interface nfci_rsp_if;
  import nfci_pkg::*;
  logic   valid;
  logic   ready;
  word_t  read_data;
  flags_t error_flags;
  logic   ready_pulse;
  modport source (output valid, read_data, error_flags, ready_pulse, input ready);
  modport sink (input valid, read_data, error_flags, ready_pulse, output ready);
endinterface

// File: rtl/core/nfci_colmod.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: 64-bit address modulo a 14-bit divisor, one bit a cycle.
// Depends on nfci_pkg.
module nfci_colmod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  nfci_pkg::word_t      dividend,
  input  logic [13:0]          divisor,
  output logic                 done,
  output logic [13:0]          rem
);
  import nfci_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  word_t       shreg;
  logic [13:0] r;
  logic [13:0] dv;
  logic [14:0] trial;

  assign trial = {r, shreg[63]};
  assign rem   = (dv == 14'd0) ? 14'd0 : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && cnt == 6'd63;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        r     <= '0;
        dv    <= divisor;
      end else if (busy) begin
        // restoring step: keep the partial remainder below the divisor
        if (trial >= {1'b0, dv}) begin
          r <= 14'(trial - {1'b0, dv});
        end else begin
          r <= trial[13:0];
        end
        shreg <= {shreg[62:0], 1'b0};
        cnt   <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: rtl/core/nand_flash_command_interface_top.sv
`timescale 1ns / 1ps
// Top level of the NAND flash command interface: page buffer and flash array
// memories, command sequencer, APB register file. Depends on nfci_pkg,
// nfci_chan_if and nfci_colmod.
//
//  channel | dir | handshake           | payload
//  req     | in  | valid/ready         | req_type, bus_offset, access_bytes, write_data
//  rsp     | out | valid/ready         | read_data, error_flags, ready_pulse
//  apb     | in  | psel/penable/pready | paddr, pwdata, prdata
//
// One item at a time: the next request is taken only once the result of the last one is in
// the output register. Data port: min(size, 8) bytes, one buffer byte a cycle. Page read and
// program: the column remainder is computed first, then the bytes are copied.
// After reset a clearing pass zeroes both memories; req.ready is low meanwhile.
// A result held by a stalled rsp does not block the next request being taken.
module nand_flash_command_interface_top #(
  parameter int unsigned BUF_BYTES = 4096,
  parameter int unsigned NUM_PAGES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  nfci_req_if.sink                    req,
  nfci_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfci_pkg::CFG_AW-1:0] paddr,
  input  logic [nfci_pkg::CFG_DW-1:0] pwdata,
  output logic [nfci_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import nfci_pkg::*;

  localparam int unsigned BW = $clog2(BUF_BYTES);
  localparam int unsigned CW = $clog2(BUF_BYTES + 1);
  localparam int unsigned PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned EW = $clog2(NUM_PAGES + 1) + 19;
  localparam logic [14:0] BUF_LIM = 15'(BUF_BYTES);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_WR     = 4'd4;
  localparam logic [3:0] S_ID     = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_SPAN1  = 4'd7;
  localparam logic [3:0] S_SPAN2  = 4'd8;
  localparam logic [3:0] S_COPY   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  // configuration
  logic [12:0] page_bytes;
  logic [8:0]  spare_bytes;
  logic        write_enabled;
  word_t       device_id;
  logic        shared_bus_off;

  // device state
  logic [12:0] ptr;
  word_t       rca;
  logic [3:0]  acnt;
  byte_t       last_cmd;
  byte_t       status;

  // item
  logic [3:0]  state;
  logic        it_wr;
  logic [19:0] it_off;
  logic [3:0]  it_size;
  word_t       it_data;
  logic [3:0]  nb;
  logic [3:0]  idx;
  word_t       rd_acc;
  flags_t      fl;
  logic        pulse;
  logic        pend;
  logic [2:0]  lane;
  logic [ARRAY_AW:0] clr;

  // page transfer
  logic          op_rd;
  logic          div_start;
  logic          div_done;
  logic [13:0]   div_rem;
  logic [13:0]   col;
  logic [13:0]   col_s;
  logic [13:0]   len;
  logic [CW-1:0] n;
  logic [CW-1:0] k;
  logic [CW-1:0] cp_a;
  logic          cp_pend;
  logic [EW-1:0] prod;
  logic [EW-1:0] lim_arr;
  logic          row_ok;
  logic [EW-1:0] endv;
  logic [ARRAY_AW-1:0] base;

  // output register
  logic   out_valid;
  word_t  out_rd;
  flags_t out_fl;
  logic   out_pulse;

  // memories
  byte_t buf_mem [BUF_BYTES];
  byte_t fla_mem [ARRAY_BYTES];
  logic          buf_we;
  logic [BW-1:0] buf_wa;
  byte_t         buf_wd;
  logic [BW-1:0] buf_ra;
  byte_t         buf_rd;
  logic                fla_we;
  logic [ARRAY_AW-1:0] fla_wa;
  byte_t               fla_wd;
  logic [ARRAY_AW-1:0] fla_ra;
  byte_t               fla_rd;

  logic [13:0] pp;
  logic [14:0] lim;
  logic        ptr_in;
  byte_t       b;
  logic        rg_rsvd, rg_addr, rg_cmd;
  logic        cmd_ok;

  assign pp      = 14'(page_bytes) + 14'(spare_bytes);
  assign lim     = ({1'b0, pp} < BUF_LIM) ? {1'b0, pp} : BUF_LIM;
  assign ptr_in  = {2'b00, ptr} < lim;
  assign b       = it_data[7:0];
  assign rg_rsvd = it_off >= OFF_RSVD;
  assign rg_addr = !rg_rsvd && it_off >= OFF_ADDR;
  assign rg_cmd  = it_off < OFF_ADDR && it_off >= OFF_CMD;
  assign cmd_ok  = it_wr && rg_cmd && it_size == 4'd1;
  assign endv    = prod + EW'(col_s) + EW'(len);

  assign req.ready     = state == S_IDLE;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rd;
  assign rsp.error_flags = out_fl;
  assign rsp.ready_pulse = out_pulse;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[5:3])
      REG_PAGE_BYTES:  prdata = 64'(page_bytes);
      REG_SPARE_BYTES: prdata = 64'(spare_bytes);
      REG_WRITE_EN:    prdata = 64'(write_enabled);
      REG_DEVICE_ID:   prdata = device_id;
      REG_SHARED_OFF:  prdata = 64'(shared_bus_off);
      default:         prdata = '0;
    endcase
  end

  nfci_colmod u_colmod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rca),
    .divisor  ({page_bytes, 1'b0}),
    .done     (div_done),
    .rem      (div_rem)
  );

  // memory port steering
  always_comb begin
    buf_we = 1'b0;
    buf_wa = '0;
    buf_wd = '0;
    buf_ra = BW'(ptr);
    fla_we = 1'b0;
    fla_wa = '0;
    fla_wd = '0;
    fla_ra = '0;
    case (state)
      S_CLEAR: begin
        buf_we = clr < (ARRAY_AW + 1)'(BUF_BYTES);
        buf_wa = BW'(clr);
        fla_we = 1'b1;
        fla_wa = ARRAY_AW'(clr);
      end
      S_DECODE: begin
        buf_we = cmd_ok && b == OP_STATUS;
        buf_wd = status;
      end
      S_WR: begin
        buf_we = idx < nb && ptr_in;
        buf_wa = BW'(ptr);
        buf_wd = it_data[{idx[2:0], 3'b000} +: 8];
      end
      S_ID: begin
        buf_we = idx < 4'd8;
        buf_wa = BW'(idx);
        buf_wd = device_id[{idx[2:0], 3'b000} +: 8];
      end
      S_COPY: begin
        if (op_rd) begin
          fla_ra = ARRAY_AW'(base + ARRAY_AW'(k));
          buf_we = cp_pend;
          buf_wa = BW'(cp_a);
          buf_wd = fla_rd;
        end else begin
          buf_ra = BW'(k);
          fla_we = cp_pend;
          fla_wa = ARRAY_AW'(base + ARRAY_AW'(cp_a));
          fla_wd = buf_rd;
        end
      end
      default: begin
        buf_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_wa] <= buf_wd;
    end
    buf_rd <= buf_mem[buf_ra];
  end

  always_ff @(posedge clk) begin
    if (fla_we) begin
      fla_mem[fla_wa] <= fla_wd;
    end
    fla_rd <= fla_mem[fla_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr            <= '0;
      ptr            <= '0;
      rca            <= '0;
      acnt           <= '0;
      last_cmd       <= OP_READ;
      status         <= '0;
      out_valid      <= 1'b0;
      pend           <= 1'b0;
      cp_pend        <= 1'b0;
      div_start      <= 1'b0;
      page_bytes     <= 13'd2048;
      spare_bytes    <= 9'd64;
      write_enabled  <= 1'b1;
      device_id      <= '0;
      shared_bus_off <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[5:3])
          REG_PAGE_BYTES:  page_bytes     <= pwdata[12:0];
          REG_SPARE_BYTES: spare_bytes    <= pwdata[8:0];
          REG_WRITE_EN:    write_enabled  <= pwdata[0];
          REG_DEVICE_ID:   device_id      <= pwdata;
          REG_SHARED_OFF:  shared_bus_off <= pwdata[0];
          default:         ;
        endcase
      end

      // drop the beat once taken, unless a new one replaces it this cycle
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      pend      <= state == S_RD && idx < nb && ptr_in;
      cp_pend   <= state == S_COPY && k < n;
      div_start <= state == S_DECODE && cmd_ok && (b == OP_READ_GO || b == OP_PROG_GO);
      if (pend) begin
        rd_acc[{lane, 3'b000} +: 8] <= buf_rd;
      end

      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (ARRAY_AW + 1)'(ARRAY_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            it_wr   <= req.req_type;
            it_off  <= req.bus_offset[19:0];
            it_size <= req.access_bytes;
            it_data <= req.write_data;
            nb      <= (req.access_bytes > 4'd8) ? 4'd8 : req.access_bytes;
            idx     <= '0;
            rd_acc  <= '0;
            fl      <= '0;
            pulse   <= 1'b0;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!it_wr) begin
            state <= S_RD;
          end else begin
            if (shared_bus_off) fl[FL_MODE] <= 1'b1;
            if (rg_rsvd) begin
              fl[FL_RSVD] <= 1'b1;
              state       <= S_DONE;
            end else if (rg_addr) begin
              state <= S_DONE;
              if (it_size != 4'd1) begin
                fl[FL_ALIGN] <= 1'b1;
              end else if (last_cmd == OP_READ || last_cmd == OP_PROG) begin
                if (acnt < 4'd8) begin
                  rca  <= rca | (64'(b) << {acnt[2:0], 3'b000});
                  acnt <= acnt + 4'd1;
                end
              end else if (last_cmd == OP_ID) begin
                ptr <= 13'(b);
              end else begin
                fl[FL_CMD] <= 1'b1;
              end
            end else if (rg_cmd) begin
              if (it_size != 4'd1) begin
                fl[FL_ALIGN] <= 1'b1;
                state        <= S_DONE;
              end else begin
                case (b)
                  OP_RESET: begin
                    pulse <= 1'b1;
                    state <= S_DONE;
                  end
                  OP_READ, OP_PROG: begin
                    rca   <= '0;
                    acnt  <= '0;
                    ptr   <= '0;
                    state <= S_DONE;
                  end
                  OP_READ_GO, OP_PROG_GO: begin
                    if (last_cmd != ((b == OP_READ_GO) ? OP_READ : OP_PROG)) begin
                      fl[FL_SEQ] <= 1'b1;
                    end
                    status    <= {write_enabled, 1'b1, 6'b000000};
                    pulse     <= 1'b1;
                    op_rd     <= b == OP_READ_GO;
                    state     <= S_DIV;
                  end
                  OP_STATUS: begin
                    ptr   <= '0;
                    state <= S_DONE;
                  end
                  OP_ID: begin
                    ptr   <= '0;
                    state <= S_ID;
                  end
                  default: begin
                    fl[FL_CMD] <= 1'b1;
                    state      <= S_DONE;
                  end
                endcase
                last_cmd <= b;
              end
            end else begin
              state <= S_WR;
            end
          end
        end
        S_RD: begin
          if (idx < nb) begin
            if (ptr_in) begin
              lane <= idx[2:0];
              ptr  <= ptr + 13'd1;
            end else begin
              fl[FL_BUF] <= 1'b1;
            end
            idx <= idx + 4'd1;
          end else if (!pend) begin
            state <= S_DONE;
          end
        end
        S_WR: begin
          if (idx < nb) begin
            if (ptr_in) begin
              ptr <= ptr + 13'd1;
            end else begin
              fl[FL_BUF] <= 1'b1;
            end
            idx <= idx + 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_ID: begin
          if (idx < 4'd8) begin
            idx <= idx + 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            col   <= div_rem;
            state <= S_SPAN1;
          end
        end
        S_SPAN1: begin
          prod    <= EW'(rca[16 +: PW]) * EW'(pp);
          lim_arr <= EW'(NUM_PAGES) * EW'(pp);
          row_ok  <= rca[63:16] < 48'(NUM_PAGES);
          if (op_rd) begin
            col_s <= '0;
            len   <= pp;
            n     <= ({1'b0, pp} < BUF_LIM) ? CW'(pp) : CW'(BUF_BYTES);
          end else begin
            col_s <= col;
            len   <= ({2'b00, ptr} < BUF_LIM) ? 14'(ptr) : 14'(BUF_BYTES);
            n     <= ({2'b00, ptr} < BUF_LIM) ? CW'(ptr) : CW'(BUF_BYTES);
          end
          state <= S_SPAN2;
        end
        S_SPAN2: begin
          base <= ARRAY_AW'(prod + EW'(col_s));
          k    <= '0;
          if (op_rd) ptr <= col[12:0];
          if (row_ok && endv <= lim_arr && endv <= EW'(ARRAY_BYTES)) begin
            state <= S_COPY;
          end else begin
            fl[FL_ARRAY] <= 1'b1;
            state        <= S_DONE;
          end
        end
        S_COPY: begin
          // read source at k, write destination in the next cycle
          if (k < n) begin
            cp_a    <= k;
            k       <= k + 1'b1;
          end else if (!cp_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_rd    <= rd_acc;
            out_fl    <= fl;
            out_pulse <= pulse;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/nfci_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the NAND flash command interface and the bind that
// attaches them to the top level. Depends on nfci_pkg.
module nfci_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input nfci_pkg::word_t        rsp_read_data,
  input nfci_pkg::flags_t       rsp_error_flags,
  input logic                   rsp_ready_pulse
);
  import nfci_pkg::*;

  // memories are swept after reset: no request taken the cycle after
  a_clear_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
      && $stable(rsp_error_flags) && $stable(rsp_ready_pulse))
    else $error("stalled response beat changed");

  // array range and sequence faults only come from a page command, which cycles busy
  a_page_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_error_flags[FL_ARRAY] || rsp_error_flags[FL_SEQ]) |-> rsp_ready_pulse)
    else $error("page fault without ready pulse");

  a_region_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_error_flags[FL_ALIGN] && rsp_error_flags[FL_BUF])
      && !(rsp_error_flags[FL_RSVD] && rsp_ready_pulse))
    else $error("flags from different regions in one beat");
endmodule

bind nand_flash_command_interface_top nfci_checker u_nfci_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_read_data   (rsp.read_data),
  .rsp_error_flags (rsp.error_flags),
  .rsp_ready_pulse (rsp.ready_pulse)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for nand_flash_command_interface_top: directed table, then
// random command sequences over several register settings. Depends on nfci_pkg, nfci_chan_if.
module testbench;
  import nfci_pkg::*;

  localparam int unsigned BUF_BYTES = 4096;
  localparam int unsigned NUM_PAGES = 64;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        req_type;
    logic [25:0] bus_offset;
    logic [3:0]  access_bytes;
    word_t       write_data;
  } bus_access_t;

  typedef struct packed {
    word_t  read_data;
    flags_t error_flags;
    logic   ready_pulse;
  } access_result_t;

  typedef struct packed {
    bus_access_t    acc;
    logic           typed;
    access_result_t res;
  } table_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  nfci_req_if req ();
  nfci_rsp_if rsp ();

  nand_flash_command_interface_top #(.BUF_BYTES(BUF_BYTES), .NUM_PAGES(NUM_PAGES)) u_top (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // device shadow
  logic [12:0] cfg_page;
  logic [8:0]  cfg_spare;
  logic        cfg_we, cfg_shared;
  word_t       cfg_id;
  byte_t       shadow_buf [BUF_BYTES];
  byte_t       flash_mem [ARRAY_BYTES];
  logic [12:0] buf_ptr;
  word_t       row_col;
  int unsigned addr_count;
  byte_t       last_cmd;
  byte_t       status_reg;

  access_result_t pending_q[$];
  table_row_t     directed_q[$];
  longint unsigned cycles;
  int unsigned fails, n_items, n_results, n_page_ops;
  logic hold_off;
  bit   steady;
  int   rx_wait;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned buf_limit();
    int unsigned n;
    n = cfg_page + cfg_spare;
    return n < BUF_BYTES ? n : BUF_BYTES;
  endfunction

  function automatic bit span_fits(longint unsigned row, longint unsigned pp,
                                   longint unsigned col, longint unsigned len);
    longint unsigned stop;
    if (row >= NUM_PAGES) return 1'b0;
    stop = row * pp + col + len;
    return stop <= NUM_PAGES * pp && stop <= ARRAY_BYTES;
  endfunction

  function automatic void predict_access(input bus_access_t a, output access_result_t r);
    logic [19:0] off;
    int unsigned nb, lim, i;
    byte_t b;
    longint unsigned pp, row, col, len, m;
    off = a.bus_offset[19:0];
    nb = a.access_bytes > 8 ? 8 : a.access_bytes;
    lim = buf_limit();
    b = a.write_data[7:0];
    r = '0;
    if (!a.req_type) begin
      for (i = 0; i < nb; i++) begin
        if (buf_ptr >= lim) r.error_flags[FL_BUF] = 1'b1;
        else begin
          r.read_data[8*i +: 8] = shadow_buf[buf_ptr];
          buf_ptr = buf_ptr + 1;
        end
      end
      return;
    end
    if (cfg_shared) r.error_flags[FL_MODE] = 1'b1;
    if (off >= OFF_RSVD) begin
      r.error_flags[FL_RSVD] = 1'b1;
    end else if (off >= OFF_ADDR) begin
      if (a.access_bytes != 1) r.error_flags[FL_ALIGN] = 1'b1;
      else if (last_cmd == OP_READ || last_cmd == OP_PROG) begin
        if (addr_count < 8) begin
          row_col[8*addr_count +: 8] = b;
          addr_count++;
        end
      end else if (last_cmd == OP_ID) buf_ptr = {5'd0, b};
      else r.error_flags[FL_CMD] = 1'b1;
    end else if (off >= OFF_CMD) begin
      if (a.access_bytes != 1) r.error_flags[FL_ALIGN] = 1'b1;
      else begin
        case (b)
          OP_RESET: r.ready_pulse = 1'b1;
          OP_READ, OP_PROG: begin
            row_col = '0;
            addr_count = 0;
            buf_ptr = '0;
          end
          OP_READ_GO, OP_PROG_GO: begin
            if (last_cmd != (b == OP_READ_GO ? OP_READ : OP_PROG))
              r.error_flags[FL_SEQ] = 1'b1;
            status_reg = cfg_we ? 8'h80 : 8'h00;
            pp = cfg_page + cfg_spare;
            row = row_col >> 16;
            m = 2 * cfg_page;
            col = m != 0 ? row_col % m : 0;
            if (b == OP_READ_GO) begin
              buf_ptr = col[12:0];
              if (span_fits(row, pp, 0, pp))
                for (i = 0; i < (pp < BUF_BYTES ? pp : BUF_BYTES); i++)
                  shadow_buf[i] = flash_mem[row * pp + i];
              else r.error_flags[FL_ARRAY] = 1'b1;
            end else begin
              len = buf_ptr < BUF_BYTES ? buf_ptr : BUF_BYTES;
              if (span_fits(row, pp, col, len))
                for (i = 0; i < len; i++) flash_mem[row * pp + col + i] = shadow_buf[i];
              else r.error_flags[FL_ARRAY] = 1'b1;
            end
            status_reg |= 8'h40;
            r.ready_pulse = 1'b1;
            n_page_ops++;
          end
          OP_STATUS: begin
            buf_ptr = '0;
            shadow_buf[0] = status_reg;
          end
          OP_ID: begin
            buf_ptr = '0;
            for (i = 0; i < 8; i++) shadow_buf[i] = cfg_id[8*i +: 8];
          end
          default: r.error_flags[FL_CMD] = 1'b1;
        endcase
        last_cmd = b;
      end
    end else begin
      for (i = 0; i < nb; i++) begin
        if (buf_ptr >= lim) r.error_flags[FL_BUF] = 1'b1;
        else begin
          shadow_buf[buf_ptr] = a.write_data[8*i +: 8];
          buf_ptr = buf_ptr + 1;
        end
      end
    end
  endfunction

  task automatic send(input bus_access_t a, input bit typed = 1'b0,
                      input access_result_t want = '0);
    access_result_t r;
    int g;
    g = steady ? 0 : gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.req_type     <= a.req_type;
    req.bus_offset   <= a.bus_offset;
    req.access_bytes <= a.access_bytes;
    req.write_data   <= a.write_data;
    do @(posedge clk); while (!req.ready);
    predict_access(a, r);
    pending_q.push_back(typed ? want : r);
    n_items++;
  endtask

  function automatic logic [25:0] window_hi(input logic [19:0] low);
    return {6'($urandom), low};
  endfunction

  function automatic bus_access_t cmd_beat(input byte_t b);
    return '{1'b1, window_hi(20'($urandom_range(OFF_CMD, OFF_ADDR - 1))), 4'd1, {56'($urandom), b}};
  endfunction

  function automatic bus_access_t addr_beat(input byte_t b);
    return '{1'b1, window_hi(20'($urandom_range(OFF_ADDR, OFF_RSVD - 1))), 4'd1,
             {56'($urandom), b}};
  endfunction

  function automatic bus_access_t data_beat(input logic wr, input logic [3:0] sz);
    return '{wr, window_hi(20'($urandom_range(0, OFF_CMD - 1))), sz, {$urandom, $urandom}};
  endfunction

  task automatic send_address();
    int unsigned col, row, n, i;
    col = $urandom_range(0, buf_limit() < 48 ? buf_limit() : 48);
    row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NUM_PAGES - 1);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : 3;
    send(addr_beat(col[7:0]));
    send(addr_beat(col[15:8]));
    send(addr_beat(row[7:0]));
    for (i = 3; i < n; i++) send(addr_beat(8'($urandom)));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start, k, i;
    start = n_items;
    while (n_items - start < count) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        send(cmd_beat(OP_PROG));
        send_address();
        for (i = $urandom_range(1, 4); i > 0; i--) send(data_beat(1'b1, 4'($urandom_range(1, 8))));
        send(cmd_beat(OP_PROG_GO));
      end else if (k < 55) begin
        send(cmd_beat(OP_READ));
        send_address();
        send(cmd_beat(OP_READ_GO));
        for (i = $urandom_range(1, 4); i > 0; i--) send(data_beat(1'b0, 4'($urandom_range(1, 8))));
      end else if (k < 63) begin
        send(cmd_beat(OP_STATUS));
        send(data_beat(1'b0, 4'($urandom_range(1, 2))));
      end else if (k < 71) begin
        send(cmd_beat(OP_ID));
        if ($urandom_range(0, 1)) send(addr_beat(8'($urandom_range(0, 7))));
        send(data_beat(1'b0, 4'($urandom_range(1, 8))));
      end else if (k < 75) begin
        send(cmd_beat(OP_RESET));
      end else if (k < 82) begin
        send(cmd_beat(8'($urandom)));
      end else begin
        send('{1'($urandom), 26'($urandom), 4'($urandom_range(0, 15)), {$urandom, $urandom}});
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input word_t v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PAGE_BYTES:  cfg_page = v[12:0];
      REG_SPARE_BYTES: cfg_spare = v[8:0];
      REG_WRITE_EN:    cfg_we = v[0];
      REG_DEVICE_ID:   cfg_id = v;
      REG_SHARED_OFF:  cfg_shared = v[0];
      default: ;
    endcase
  endtask

  task automatic settle_and_configure(input int unsigned pg, input int unsigned sp,
                                      input logic we, input word_t id, input logic sh);
    @(posedge clk);
    req.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (4) @(posedge clk);
    write_reg(REG_PAGE_BYTES, 64'(pg));
    write_reg(REG_SPARE_BYTES, 64'(sp));
    write_reg(REG_WRITE_EN, 64'(we));
    write_reg(REG_DEVICE_ID, id);
    write_reg(REG_SHARED_OFF, 64'(sh));
  endtask

  function automatic void add_row(input bus_access_t a, input logic typed,
                                  input word_t rd, input int unsigned fl, input logic pulse);
    directed_q.push_back('{a, typed, '{rd, 7'(fl), pulse}});
  endfunction

  // response checker
  always @(posedge clk) begin
    access_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: read_data %h", rsp.read_data);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (rsp.read_data !== want.read_data) begin
          $error("read_data expected %h got %h", want.read_data, rsp.read_data);
          fails++;
        end
        if (rsp.error_flags !== want.error_flags) begin
          $error("error_flags expected %b got %b", want.error_flags, rsp.error_flags);
          fails++;
        end
        if (rsp.ready_pulse !== want.ready_pulse) begin
          $error("ready_pulse expected %b got %b", want.ready_pulse, rsp.ready_pulse);
          fails++;
        end
      end
    end
  end

  // response side stalls
  always @(posedge clk) begin
    if (rst || hold_off) rsp.ready <= 1'b0;
    else if (rx_wait > 0) begin
      rsp.ready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (!steady) rx_wait = gap_len();
    end
  end

  // long hold-off on the response side while requests keep coming
  initial begin
    hold_off = 1'b0;
    wait (n_results >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    table_row_t t;
    cycles = 0; fails = 0; n_items = 0; n_results = 0; n_page_ops = 0;
    steady = 1'b0; rx_wait = 0;
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    req.valid <= 1'b0; req.req_type <= 1'b0; req.bus_offset <= '0;
    req.access_bytes <= 4'd1; req.write_data <= '0;
    cfg_page = 13'd2048; cfg_spare = 9'd64; cfg_we = 1'b1; cfg_id = '0; cfg_shared = 1'b0;
    foreach (shadow_buf[i]) shadow_buf[i] = '0;
    foreach (flash_mem[i]) flash_mem[i] = '0;
    buf_ptr = '0; row_col = '0; addr_count = 0; last_cmd = OP_READ; status_reg = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_row('{1'b0, 26'h0000010, 4'd8, '0}, 1, '0, 0, 0);
    add_row('{1'b1, 26'h3fc0000, 4'd1, 64'h5a}, 1, '0, 1 << FL_RSVD, 0);
    add_row('{1'b1, 26'h0010000, 4'd15, 64'h1}, 1, '0, 1 << FL_ALIGN, 0);
    add_row('{1'b1, 26'h0007fff, 4'd0, '1}, 1, '0, 0, 0);
    add_row(cmd_beat(8'h55), 1, '0, 1 << FL_CMD, 0);
    add_row(addr_beat(8'h12), 1, '0, 1 << FL_CMD, 0);
    add_row('{1'b1, 26'h3f08000, 4'd1, {56'd0, OP_READ_GO}}, 1, '0, 1 << FL_SEQ, 1);
    add_row(cmd_beat(OP_RESET), 1, '0, 0, 1);
    add_row(cmd_beat(OP_STATUS), 0, '0, 0, 0);
    add_row(data_beat(1'b0, 4'd1), 1, 64'hc0, 0, 0);
    add_row(cmd_beat(OP_ID), 0, '0, 0, 0);
    add_row(data_beat(1'b0, 4'd8), 1, '0, 0, 0);
    add_row(addr_beat(8'h05), 0, '0, 0, 0);
    add_row(cmd_beat(OP_PROG), 0, '0, 0, 0);
    add_row(addr_beat(8'h00), 0, '0, 0, 0);
    add_row(addr_beat(8'h00), 0, '0, 0, 0);
    add_row(addr_beat(8'h01), 0, '0, 0, 0);
    add_row('{1'b1, 26'h2000000, 4'd8, 64'h0123456789abcdef}, 0, '0, 0, 0);
    add_row(cmd_beat(OP_PROG_GO), 1, '0, 0, 1);
    add_row(cmd_beat(OP_READ), 0, '0, 0, 0);
    add_row(addr_beat(8'h00), 0, '0, 0, 0);
    add_row(addr_beat(8'h00), 0, '0, 0, 0);
    add_row(addr_beat(8'h01), 0, '0, 0, 0);
    add_row(cmd_beat(OP_READ_GO), 1, '0, 0, 1);
    add_row('{1'b0, 26'h3ff7ff8, 4'd8, '1}, 1, 64'h0123456789abcdef, 0, 0);
    while (directed_q.size() > 0) begin
      t = directed_q.pop_front();
      send(t.acc, t.typed, t.res);
    end

    settle_and_configure(64, 16, 1'b1, {$urandom, $urandom}, 1'b0);
    run_random(200);
    settle_and_configure(0, 0, 1'b0, '1, 1'b1);
    run_random(60);
    settle_and_configure(4096, 256, 1'b1, {$urandom, $urandom}, 1'b0);
    run_random(30);
    settle_and_configure(16, 4, 1'b0, {$urandom, $urandom}, 1'b1);
    run_random(150);
    settle_and_configure(512, 64, 1'b1, {$urandom, $urandom}, 1'b0);
    // back-to-back on both sides
    steady = 1'b1;
    run_random(60);
    steady = 1'b0;
    run_random(100);

    @(posedge clk);
    req.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d bus accesses, %0d results, %0d page reads/programs, 6 settings",
             n_items, n_results, n_page_ops);
    if (fails == 0 && pending_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: nand_flash_command_interface_top.f
rtl/core/nfci_pkg.sv
rtl/core/nfci_chan_if.sv
rtl/core/nfci_colmod.sv
rtl/core/nand_flash_command_interface_top.sv
rtl/core/nfci_checker.sv
tb/testbench.sv
